>>> rtl/ptra_pkg.sv
package ptra_pkg;

  // Default table depth
  localparam int unsigned PAGES_DEF = 4096;

  // Fixed field widths
  localparam int unsigned PAGE_W = 20;
  localparam int unsigned CNT_W  = 13;
  localparam int unsigned TYPE_W = 5;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;

  // Run counter is one bit wider than a count
  localparam int unsigned RUN_W = CNT_W + 1;

  // Reset values
  localparam logic [CNT_W-1:0]  TOTAL_RST = CNT_W'(4096);
  localparam logic [TYPE_W-1:0] FREE_RST  = TYPE_W'(2);
  localparam logic [CNT_W-1:0]  HINT_RST  = CNT_W'(4096);

  // Operation codes
  localparam logic [KIND_W-1:0] KIND_MARK    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ALLOC   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FIND    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_BELOW   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CHECK   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_REFRESH = 3'd5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOWEST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FREE   = 2'd2;

  // Scan modes of the shared compare unit
  typedef enum logic [2:0] {
    SM_UP,
    SM_DOWN,
    SM_CHECK,
    SM_REFRESH,
    SM_COUNT
  } scan_mode_e;

  // Scan unit result
  typedef struct packed {
    logic             hit;
    logic [RUN_W-1:0] run_next;
  } scan_res_t;

endpackage

>>> rtl/ptra_ram.sv
module ptra_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> rtl/ptra_scan.sv
module ptra_scan (
  input  ptra_pkg::scan_mode_e            mode_i,
  input  logic [ptra_pkg::TYPE_W-1:0]     rdata_i,
  input  logic [ptra_pkg::TYPE_W-1:0]     free_code_i,
  input  logic [ptra_pkg::RUN_W-1:0]      run_i,
  input  logic [ptra_pkg::CNT_W-1:0]      need_i,
  output ptra_pkg::scan_res_t             res_o
);
  import ptra_pkg::*;

  logic             is_free;
  logic [RUN_W-1:0] run_inc;

  assign is_free = (rdata_i == free_code_i);
  assign run_inc = run_i + RUN_W'(1);

  // Per-entry compare and run tracking
  always_comb begin
    res_o.hit      = 1'b0;
    res_o.run_next = '0;
    unique case (mode_i) inside
      SM_UP, SM_DOWN: begin
        res_o.run_next = is_free ? run_inc : '0;
        res_o.hit      = is_free && (run_inc >= RUN_W'(need_i));
      end
      SM_CHECK: begin
        res_o.hit = !is_free;
      end
      SM_REFRESH: begin
        res_o.hit = is_free;
      end
      SM_COUNT: begin
        res_o.run_next = is_free ? run_inc : run_i;
      end
      default: begin
        res_o.hit = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/page_table_run_allocator_core.sv
// Page table allocator: one memory type code per page in a table RAM
// with one write and one read port, plus a free-limit hint and a running
// free count. Each item yields one result beat. Range writes read the old
// type of each entry, then write it; scans (find, below, check, refresh)
// stream one entry per cycle through the shared compare unit. After reset
// the table is cleared and then its first min(total_pages, PAGES) entries
// are counted; writes to total_pages or free_code also start such a count.
// Input is not accepted during either pass; configuration beats are taken
// during the clear pass and while idle.
module page_table_run_allocator_core #(
  parameter int unsigned PAGES = ptra_pkg::PAGES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [ptra_pkg::KIND_W-1:0]     in_kind_i,
  input  logic [ptra_pkg::PAGE_W-1:0]     in_start_page_i,
  input  logic [ptra_pkg::CNT_W-1:0]      in_page_count_i,
  input  logic [ptra_pkg::TYPE_W-1:0]     in_mem_type_i,
  input  logic                            in_from_end_i,
  input  logic [ptra_pkg::CNT_W-1:0]      in_limit_page_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            out_ok_o,
  output logic [ptra_pkg::PAGE_W-1:0]     out_found_page_o,
  output logic [ptra_pkg::CNT_W-1:0]      out_free_pages_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ptra_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ptra_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import ptra_pkg::*;

  localparam int unsigned IW  = $clog2(PAGES);
  localparam int unsigned CW  = IW + 1;
  localparam int unsigned AW  = ((CW > PAGE_W + 1) ? CW : PAGE_W + 1) + 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_RC_START,
    ST_IDLE,
    ST_SETUP,
    ST_WR_RD,
    ST_WR_WR,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e                state_q, state_d;
  scan_mode_e            mode_q, mode_d;
  logic [AW-1:0]         ptr_q, ptr_d;
  logic [AW-1:0]         rem_q, rem_d;
  logic [AW-1:0]         raddr_q, raddr_d;
  logic                  rv_q, rv_d;
  logic [RUN_W-1:0]      run_q, run_d;

  logic [PAGE_W-1:0]     lowest_q, lowest_d;
  logic [CNT_W-1:0]      total_q, total_d;
  logic [TYPE_W-1:0]     fcode_q, fcode_d;
  logic [CNT_W-1:0]      hint_q, hint_d;
  logic [CNT_W-1:0]      ftot_q, ftot_d;

  logic [KIND_W-1:0]     kind_q, kind_d;
  logic [PAGE_W-1:0]     start_q, start_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [TYPE_W-1:0]     type_q, type_d;
  logic                  fend_q, fend_d;
  logic [CNT_W-1:0]      limit_q, limit_d;

  logic                  ok_q, ok_d;
  logic [PAGE_W-1:0]     found_q, found_d;

  logic                  ovalid_q, ovalid_d;
  logic                  ook_q, ook_d;
  logic [PAGE_W-1:0]     ofound_q, ofound_d;
  logic [CNT_W-1:0]      ofree_q, ofree_d;

  logic                  we;
  logic [TYPE_W-1:0]     wdata;
  logic [TYPE_W-1:0]     rdata;
  scan_res_t             sres;

  logic                  cfg_acc, in_acc;
  logic [AW-1:0]         n_eff, lp, st, cnt, rel, rel_end, hint_cl, top;
  logic                  inb;

  // Table RAM and shared compare unit
  ptra_ram #(
    .WIDTH (TYPE_W),
    .DEPTH (PAGES)
  ) u_type_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (ptr_q[IW-1:0]),
    .wdata_i (wdata),
    .raddr_i (ptr_q[IW-1:0]),
    .rdata_o (rdata)
  );

  ptra_scan u_scan (
    .mode_i      (mode_q),
    .rdata_i     (rdata),
    .free_code_i (fcode_q),
    .run_i       (run_q),
    .need_i      (count_q),
    .res_o       (sres)
  );

  assign cfg_ready_o = (state_q == ST_CLEAR) || (state_q == ST_IDLE);
  assign in_ready_o  = (state_q == ST_IDLE) && !cfg_valid_i;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign in_acc      = in_valid_i && in_ready_o;

  assign out_valid_o      = ovalid_q;
  assign out_ok_o         = ook_q;
  assign out_found_page_o = ofound_q;
  assign out_free_pages_o = ofree_q;

  // Setup arithmetic on the captured item
  always_comb begin
    n_eff   = (AW'(total_q) < AW'(PAGES)) ? AW'(total_q) : AW'(PAGES);
    lp      = AW'(lowest_q);
    st      = AW'(start_q);
    cnt     = AW'(count_q);
    inb     = (st >= lp);
    rel     = st - lp;
    rel_end = rel + cnt;
    hint_cl = (AW'(hint_q) > n_eff) ? n_eff : AW'(hint_q);
    if (kind_q == KIND_BELOW && AW'(limit_q) <= n_eff) begin
      top = AW'(limit_q);
    end else if (kind_q == KIND_REFRESH) begin
      top = n_eff;
    end else begin
      top = hint_cl;
    end
  end

  // Table write port
  always_comb begin
    we    = (state_q == ST_CLEAR) || (state_q == ST_WR_WR);
    wdata = (state_q == ST_CLEAR) ? '0 : type_q;
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    mode_d   = mode_q;
    ptr_d    = ptr_q;
    rem_d    = rem_q;
    raddr_d  = raddr_q;
    rv_d     = 1'b0;
    run_d    = run_q;
    lowest_d = lowest_q;
    total_d  = total_q;
    fcode_d  = fcode_q;
    hint_d   = hint_q;
    ftot_d   = ftot_q;
    kind_d   = kind_q;
    start_d  = start_q;
    count_d  = count_q;
    type_d   = type_q;
    fend_d   = fend_q;
    limit_d  = limit_q;
    ok_d     = ok_q;
    found_d  = found_q;
    ovalid_d = ovalid_q && !out_ready_i;
    ook_d    = ook_q;
    ofound_d = ofound_q;
    ofree_d  = ofree_q;

    // Register writes
    if (cfg_acc) begin
      unique case (cfg_index_i)
        REG_LOWEST: lowest_d = cfg_data_i[PAGE_W-1:0];
        REG_TOTAL:  total_d  = cfg_data_i[CNT_W-1:0];
        REG_FREE:   fcode_d  = cfg_data_i[TYPE_W-1:0];
        default:    lowest_d = lowest_q;
      endcase
    end

    unique case (state_q)
      ST_CLEAR: begin
        ptr_d = ptr_q + AW'(1);
        if (ptr_q == AW'(PAGES - 1)) begin
          state_d = ST_RC_START;
        end
      end
      ST_RC_START: begin
        mode_d  = SM_COUNT;
        ptr_d   = '0;
        rem_d   = n_eff;
        run_d   = '0;
        state_d = ST_SCAN;
      end
      ST_IDLE: begin
        if (cfg_acc && (cfg_index_i == REG_TOTAL || cfg_index_i == REG_FREE)) begin
          state_d = ST_RC_START;
        end else if (in_acc) begin
          kind_d  = in_kind_i;
          start_d = in_start_page_i;
          count_d = in_page_count_i;
          type_d  = in_mem_type_i;
          fend_d  = in_from_end_i;
          limit_d = in_limit_page_i;
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        ok_d    = 1'b0;
        found_d = '0;
        run_d   = '0;
        rem_d   = (top > AW'(1)) ? top - AW'(1) : '0;
        case (kind_q) inside
          KIND_MARK, KIND_ALLOC: begin
            ok_d  = inb && (cnt == '0 || rel_end <= n_eff);
            ptr_d = rel;
            if (!inb || rel >= n_eff) begin
              rem_d = '0;
            end else if (rel_end > n_eff) begin
              rem_d = n_eff - rel;
            end else begin
              rem_d = cnt;
            end
            // Mark on a free code stores the new type like any other
            state_d = ST_WR_RD;
          end
          KIND_FIND, KIND_BELOW, KIND_REFRESH: begin
            if (kind_q != KIND_REFRESH &&
                !(kind_q == KIND_BELOW && AW'(limit_q) <= n_eff)) begin
              hint_d = CNT_W'(hint_cl);
            end
            if (kind_q == KIND_REFRESH) begin
              mode_d = SM_REFRESH;
            end else if (kind_q == KIND_BELOW || fend_q) begin
              mode_d = SM_DOWN;
            end else begin
              mode_d = SM_UP;
            end
            ptr_d   = (kind_q == KIND_FIND && !fend_q) ? AW'(1) : top - AW'(1);
            state_d = ST_SCAN;
          end
          KIND_CHECK: begin
            mode_d = SM_CHECK;
            ptr_d  = rel;
            rem_d  = cnt;
            if (!inb || rel_end > n_eff) begin
              state_d = ST_DONE;
            end else begin
              state_d = ST_SCAN;
            end
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end
      ST_WR_RD: begin
        if (rem_q == '0) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_WR_WR;
        end
      end
      ST_WR_WR: begin
        // Free count follows the change of this entry's status
        ftot_d  = ftot_q - CNT_W'(rdata == fcode_q) + CNT_W'(type_q == fcode_q);
        ptr_d   = ptr_q + AW'(1);
        rem_d   = rem_q - AW'(1);
        state_d = ST_WR_RD;
      end
      ST_SCAN: begin
        // Issue one read per cycle
        if (rem_q != '0) begin
          rv_d    = 1'b1;
          raddr_d = ptr_q;
          ptr_d   = (mode_q == SM_DOWN || mode_q == SM_REFRESH) ?
                    ptr_q - AW'(1) : ptr_q + AW'(1);
          rem_d   = rem_q - AW'(1);
        end
        // Consume the returning entry
        if (rv_q) begin
          run_d = sres.run_next;
          if (sres.hit) begin
            rv_d    = 1'b0;
            rem_d   = '0;
            state_d = ST_DONE;
            unique case (mode_q)
              SM_UP: begin
                ok_d    = 1'b1;
                found_d = PAGE_W'(raddr_q - AW'(run_q) + lp);
              end
              SM_DOWN: begin
                ok_d    = 1'b1;
                found_d = PAGE_W'(raddr_q + lp);
              end
              SM_CHECK: begin
                ok_d = 1'b0;
              end
              SM_REFRESH: begin
                ok_d   = 1'b1;
                hint_d = CNT_W'(raddr_q + AW'(1));
              end
              default: begin
                ok_d = 1'b0;
              end
            endcase
          end
        end else if (rem_q == '0) begin
          // Scan ran out without a hit
          if (mode_q == SM_COUNT) begin
            ftot_d  = CNT_W'(run_q);
            state_d = ST_IDLE;
          end else begin
            ok_d    = (mode_q == SM_CHECK);
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!ovalid_q || out_ready_i) begin
          ovalid_d = 1'b1;
          ook_d    = ok_q;
          ofound_d = found_q;
          ofree_d  = ftot_q;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      mode_q   <= SM_COUNT;
      ptr_q    <= '0;
      rem_q    <= '0;
      raddr_q  <= '0;
      rv_q     <= 1'b0;
      run_q    <= '0;
      lowest_q <= '0;
      total_q  <= TOTAL_RST;
      fcode_q  <= FREE_RST;
      hint_q   <= HINT_RST;
      ftot_q   <= '0;
      kind_q   <= '0;
      start_q  <= '0;
      count_q  <= '0;
      type_q   <= '0;
      fend_q   <= 1'b0;
      limit_q  <= '0;
      ok_q     <= 1'b0;
      found_q  <= '0;
      ovalid_q <= 1'b0;
      ook_q    <= 1'b0;
      ofound_q <= '0;
      ofree_q  <= '0;
    end else begin
      state_q  <= state_d;
      mode_q   <= mode_d;
      ptr_q    <= ptr_d;
      rem_q    <= rem_d;
      raddr_q  <= raddr_d;
      rv_q     <= rv_d;
      run_q    <= run_d;
      lowest_q <= lowest_d;
      total_q  <= total_d;
      fcode_q  <= fcode_d;
      hint_q   <= hint_d;
      ftot_q   <= ftot_d;
      kind_q   <= kind_d;
      start_q  <= start_d;
      count_q  <= count_d;
      type_q   <= type_d;
      fend_q   <= fend_d;
      limit_q  <= limit_d;
      ok_q     <= ok_d;
      found_q  <= found_d;
      ovalid_q <= ovalid_d;
      ook_q    <= ook_d;
      ofound_q <= ofound_d;
      ofree_q  <= ofree_d;
    end
  end

endmodule

>>> rtl/ptra_checker.sv
module ptra_checker #(
  parameter int unsigned PAGES = ptra_pkg::PAGES_DEF
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic [ptra_pkg::KIND_W-1:0]     in_kind_i,
  input logic [ptra_pkg::PAGE_W-1:0]     in_start_page_i,
  input logic [ptra_pkg::CNT_W-1:0]      in_page_count_i,
  input logic [ptra_pkg::TYPE_W-1:0]     in_mem_type_i,
  input logic                            in_from_end_i,
  input logic [ptra_pkg::CNT_W-1:0]      in_limit_page_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic                            out_ok_o,
  input logic [ptra_pkg::PAGE_W-1:0]     out_found_page_o,
  input logic [ptra_pkg::CNT_W-1:0]      out_free_pages_o,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_o,
  input logic [ptra_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input logic [ptra_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import ptra_pkg::*;

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_found_page_o)
      && $stable(out_ok_o) && $stable(out_free_pages_o))
    else $error("result beat changed while stalled");

  // A miss reports page zero
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ok_o |-> out_found_page_o == '0)
    else $error("found page set on a miss");

  // One item at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

  // Free count never exceeds the table
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(out_free_pages_o) <= 32'(PAGES))
    else $error("free count above table size");

endmodule

bind page_table_run_allocator_core ptra_checker #(.PAGES(PAGES)) u_ptra_checker (.*);
